@@ hw/rtl/ifhu_pkg.sv @@
package ifhu_pkg;

  localparam int unsigned HDR_WORDS_MAX = 30;
  localparam int unsigned ROUTE_ENTRIES = 2;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned ADDR_W = $clog2(HDR_WORDS_MAX);
  localparam int unsigned CNT_W  = $clog2(HDR_WORDS_MAX + 1);
  localparam int unsigned ACC_W  = 21;
  localparam int unsigned FOLD_W = 17;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [3:0] IHL_MIN = 4'd5;

  localparam logic [CNT_W-1:0] TTL_WORD    = CNT_W'(4);
  localparam logic [CNT_W-1:0] CSUM_WORD   = CNT_W'(5);
  localparam logic [CNT_W-1:0] DST_HI_WORD = CNT_W'(8);
  localparam logic [CNT_W-1:0] DST_LO_WORD = CNT_W'(9);

  localparam logic [CFG_IDX_W-1:0] REG_ROUTE0_NETWORK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE0_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE1_NETWORK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTE1_MASK    = 2'd3;

  localparam logic [1:0] STATUS_FWD      = 2'd0;
  localparam logic [1:0] STATUS_NO_ROUTE = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  typedef struct packed {
    logic hit;
    logic port;
  } route_res_t;

endpackage

@@ hw/rtl/ifhu_ram.sv @@
module ifhu_ram
  import ifhu_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [HDR_WORDS_MAX];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/ifhu_route.sv @@
module ifhu_route
  import ifhu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [31:0]          dest_i,
  output route_res_t           res_o
);

  logic [31:0] net_q  [2];
  logic [31:0] mask_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_q[0]  <= '0;
      net_q[1]  <= '0;
      mask_q[0] <= '0;
      mask_q[1] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROUTE0_NETWORK: net_q[0]  <= cfg_wdata_i;
        REG_ROUTE0_MASK:    mask_q[0] <= cfg_wdata_i;
        REG_ROUTE1_NETWORK: net_q[1]  <= cfg_wdata_i;
        REG_ROUTE1_MASK:    mask_q[1] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    for (int e = ROUTE_ENTRIES - 1; e >= 0; e--) begin
      if (((dest_i ^ net_q[e]) & mask_q[e]) == '0) begin
        res_o.hit  = 1'b1;
        res_o.port = 1'(e);
      end
    end
  end

endmodule

@@ hw/rtl/ipv4_forward_header_update_top.sv @@
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | in_word_i
// out     | output    | out_valid_o/ out_stall_i| out_word_o, out_last_o, route_port_o, status_o
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Header words are taken one per cycle into the header memory; the first waits while the output is stalled.
// After the last word, the CHECK and FINISH states fold the checksum and match the route.
// Each forwarded word is then read from memory in READ and transferred in EMIT.
// Reset clears all control state.
// Output stalls hold the output register; input stalls while a header drains.
module ipv4_forward_header_update_top
  import ifhu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_W-1:0]    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_W-1:0]    out_word_o,
  output logic                 out_last_o,
  output logic                 route_port_o,
  output logic [1:0]           status_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_CHECK,
    ST_FINISH,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   expected_q, expected_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [FOLD_W-1:0]  fold_q, fold_d;
  logic [WORD_W-1:0]  csum_q, csum_d;
  logic [31:0]        dest_q, dest_d;
  route_res_t         route_q, route_d;
  route_res_t         route_res;

  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  out_word_q, out_word_d;
  logic               out_last_q, out_last_d;
  logic               out_port_q, out_port_d;
  logic [1:0]         out_status_q, out_status_d;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               out_free, in_ready, in_fire;
  logic [3:0]         ihl;
  logic [4:0]         len_raw;
  logic [WORD_W-1:0]  adj_word, emit_word;
  logic [CNT_W-1:0]   count_nxt, ptr_nxt;

  ifhu_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_word_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ifhu_route u_route (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .dest_i      (dest_q),
    .res_o       (route_res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_ready   = ((state_q == ST_IDLE) && out_free) || (state_q == ST_COLLECT);
  assign in_stall_o = !in_ready;
  assign in_fire    = in_valid_i && in_ready;

  assign ihl       = in_word_i[11:8];
  assign len_raw   = {ihl, 1'b0};
  assign count_nxt = count_q + CNT_W'(1);
  assign ptr_nxt   = ptr_q + CNT_W'(1);

  always_comb begin
    if (count_q == TTL_WORD) begin
      adj_word = {in_word_i[15:8] - 8'd1, in_word_i[7:0]};
    end else if (count_q == CSUM_WORD) begin
      adj_word = '0;
    end else begin
      adj_word = in_word_i;
    end
  end

  always_comb begin
    if (ptr_q == TTL_WORD) begin
      emit_word = {ram_rdata[15:8] - 8'd1, ram_rdata[7:0]};
    end else if (ptr_q == CSUM_WORD) begin
      emit_word = csum_q;
    end else begin
      emit_word = ram_rdata;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    expected_d   = expected_q;
    ptr_d        = ptr_q;
    acc_d        = acc_q;
    fold_d       = fold_q;
    csum_d       = csum_q;
    dest_d       = dest_q;
    route_d      = route_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    out_port_d   = out_port_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = count_q[ADDR_W-1:0];
    ram_raddr    = ptr_q[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (ihl < IHL_MIN) begin
            out_valid_d  = 1'b1;
            out_word_d   = '0;
            out_last_d   = 1'b1;
            out_port_d   = 1'b0;
            out_status_d = STATUS_SHORT;
          end else begin
            if (len_raw > 5'(HDR_WORDS_MAX)) begin
              expected_d = CNT_W'(HDR_WORDS_MAX);
            end else begin
              expected_d = CNT_W'(len_raw);
            end
            ram_we    = 1'b1;
            ram_waddr = '0;
            acc_d     = ACC_W'(in_word_i);
            count_d   = CNT_W'(1);
            state_d   = ST_COLLECT;
          end
        end
      end
      ST_COLLECT: begin
        if (in_fire) begin
          ram_we  = 1'b1;
          acc_d   = acc_q + ACC_W'(adj_word);
          count_d = count_nxt;
          if (count_q == DST_HI_WORD) begin
            dest_d[31:16] = in_word_i;
          end
          if (count_q == DST_LO_WORD) begin
            dest_d[15:0] = in_word_i;
          end
          if (count_nxt == expected_q) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        fold_d  = FOLD_W'(acc_q[ACC_W-1:16]) + FOLD_W'(acc_q[15:0]);
        route_d = route_res;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        csum_d = ~(fold_q[15:0] + WORD_W'(fold_q[16]));
        if (route_q.hit) begin
          ptr_d   = '0;
          state_d = ST_READ;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = '0;
          out_last_d   = 1'b1;
          out_port_d   = 1'b0;
          out_status_d = STATUS_NO_ROUTE;
          state_d      = ST_IDLE;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = emit_word;
          out_last_d   = (ptr_nxt == expected_q);
          out_port_d   = route_q.port;
          out_status_d = STATUS_FWD;
          if (ptr_nxt == expected_q) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_nxt;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      expected_q  <= '0;
      ptr_q       <= '0;
      acc_q       <= '0;
      route_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      expected_q  <= expected_d;
      ptr_q       <= ptr_d;
      acc_q       <= acc_d;
      route_q     <= route_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q       <= fold_d;
    csum_q       <= csum_d;
    dest_q       <= dest_d;
    out_word_q   <= out_word_d;
    out_last_q   <= out_last_d;
    out_port_q   <= out_port_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;
  assign out_last_o   = out_last_q;
  assign route_port_o = out_port_q;
  assign status_o     = out_status_q;

endmodule
